FILE: hw/rtl/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, types and row codes for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int COL_W     = 18;
  localparam int UNIT_W    = FRAC_BITS + 2;
  localparam int TUP_W     = FRAC_BITS + 4;
  localparam int VEC_W     = 64;
  localparam int MAG_W     = 30;
  localparam int NORM_MSB  = MAG_W - 1;
  localparam int POS_W     = $clog2(VEC_W);
  localparam int SQ_W      = 2 * MAG_W + 2;
  localparam int RT_W      = SQ_W / 2;
  localparam int ISQ_STEPS = SQ_W / 2;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;

  typedef logic signed [IN_W-1:0]   word_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [TUP_W-1:0]  tup_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [COL_W-1:0]  col_t;

  typedef struct packed {
    word_t [2:0] eye;
    word_t [2:0] upv;
    unit_t [2:0] fwd;
    unit_t [2:0] side;
  } band_t;

endpackage

FILE: hw/rtl/lav_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unit
// Pipelined vector normalize: magnitude scaling, sum of squares, integer
// square root (two steps a stage) and restoring divide (three steps a stage).
// ----------------------------------------------------------------------------
module lav_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  lav_pkg::vec_t   in_vec [3],
  input  lav_pkg::band_t  in_band,
  output logic            out_vld,
  output lav_pkg::unit_t  out_vec [3],
  output lav_pkg::band_t  out_band
);

  localparam int VW      = lav_pkg::VEC_W;
  localparam int MW      = lav_pkg::MAG_W;
  localparam int SQW     = lav_pkg::SQ_W;
  localparam int RTW     = lav_pkg::RT_W;
  localparam int QW      = lav_pkg::Q_W;
  localparam int REMW    = RTW + 2;
  localparam int PW      = lav_pkg::POS_W;
  localparam int CH_N    = VW / 16;
  localparam int ISQ_PER = 2;
  localparam int ISQ_STG = (lav_pkg::ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;
  localparam int DIV_PER = 3;
  localparam int DIV_STG = (lav_pkg::DIV_STEPS + DIV_PER - 1) / DIV_PER;

  typedef logic [MW-1:0] mag_t;
  typedef struct packed {
    logic           zero;
    logic [2:0]     neg;
    mag_t [2:0]     nm;
    lav_pkg::band_t band;
  } meta_t;

  function automatic logic [3:0] msb16(input logic [15:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction

  // abs
  logic           v0_r;
  logic [2:0]     neg0_r;
  logic [VW-1:0]  mag0_r [3];
  lav_pkg::band_t band0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_vld;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg0_r[i] <= in_vec[i][VW-1];
        mag0_r[i] <= in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
      end
      band0_r <= in_band;
    end
  end

  // largest magnitude
  logic           v1_r;
  logic [2:0]     neg1_r;
  logic [VW-1:0]  mag1_r [3];
  logic [VW-1:0]  top1_r;
  lav_pkg::band_t band1_r;
  logic [VW-1:0]  top1_nxt;

  always_comb begin
    top1_nxt = mag0_r[0];
    if (mag0_r[1] > top1_nxt) top1_nxt = mag0_r[1];
    if (mag0_r[2] > top1_nxt) top1_nxt = mag0_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v0_r;
    if (adv) begin
      neg1_r  <= neg0_r;
      mag1_r  <= mag0_r;
      top1_r  <= top1_nxt;
      band1_r <= band0_r;
    end
  end

  // leading one, per 16-bit chunk
  logic           v2_r;
  logic [2:0]     neg2_r;
  logic [VW-1:0]  mag2_r [3];
  logic           nz2_r [CH_N];
  logic [3:0]     pos2_r [CH_N];
  lav_pkg::band_t band2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      band2_r <= band1_r;
      for (int c = 0; c < CH_N; c++) begin
        nz2_r[c]  <= |top1_r[16*c +: 16];
        pos2_r[c] <= msb16(top1_r[16*c +: 16]);
      end
    end
  end

  // shift direction and amount
  logic           v3_r;
  logic [2:0]     neg3_r;
  logic [VW-1:0]  mag3_r [3];
  logic           zero3_r;
  logic           right3_r;
  logic [PW-1:0]  amt3_r;
  lav_pkg::band_t band3_r;
  logic [PW-1:0]  pos_nxt;
  logic           any_nxt;

  always_comb begin
    pos_nxt = '0;
    any_nxt = 1'b0;
    for (int c = 0; c < CH_N; c++) begin
      if (nz2_r[c]) begin
        pos_nxt = PW'(c * 16) | PW'(pos2_r[c]);
        any_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      neg3_r  <= neg2_r;
      mag3_r  <= mag2_r;
      band3_r <= band2_r;
      zero3_r <= !any_nxt;
      if (pos_nxt >= PW'(lav_pkg::NORM_MSB)) begin
        right3_r <= 1'b1;
        amt3_r   <= pos_nxt - PW'(lav_pkg::NORM_MSB);
      end else begin
        right3_r <= 1'b0;
        amt3_r   <= PW'(lav_pkg::NORM_MSB) - pos_nxt;
      end
    end
  end

  // scale
  logic  v4_r;
  meta_t meta4_r;
  meta_t meta4_nxt;

  always_comb begin
    meta4_nxt.zero = zero3_r;
    meta4_nxt.neg  = neg3_r;
    meta4_nxt.band = band3_r;
    for (int i = 0; i < 3; i++) begin
      meta4_nxt.nm[i] = right3_r ? MW'(mag3_r[i] >> amt3_r) : MW'(mag3_r[i] << amt3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) meta4_r <= meta4_nxt;
  end

  // squares
  logic            v5_r;
  meta_t           meta5_r;
  logic [2*MW-1:0] sq5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
    if (adv) begin
      meta5_r <= meta4_r;
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= meta4_r.nm[i] * meta4_r.nm[i];
      end
    end
  end

  // sum
  logic           v6_r;
  meta_t          meta6_r;
  logic [SQW-1:0] sum6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
    if (adv) begin
      meta6_r <= meta5_r;
      sum6_r  <= SQW'(sq5_r[0]) + SQW'(sq5_r[1]) + SQW'(sq5_r[2]);
    end
  end

  // square root
  logic           isv_r [ISQ_STG];
  meta_t          ism_r [ISQ_STG];
  logic [SQW-1:0] isx_r [ISQ_STG];
  logic [SQW-1:0] isr_r [ISQ_STG];

  for (genvar k = 0; k < ISQ_STG; k++) begin : g_isq
    logic           v_prv;
    meta_t          m_prv;
    logic [SQW-1:0] x_prv;
    logic [SQW-1:0] r_prv;
    logic [SQW-1:0] x_nxt;
    logic [SQW-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign v_prv = v6_r;
      assign m_prv = meta6_r;
      assign x_prv = sum6_r;
      assign r_prv = '0;
    end else begin : g_next
      assign v_prv = isv_r[k-1];
      assign m_prv = ism_r[k-1];
      assign x_prv = isx_r[k-1];
      assign r_prv = isr_r[k-1];
    end

    always_comb begin
      logic [SQW:0]   rb;
      logic [SQW-1:0] b;
      x_nxt = x_prv;
      r_nxt = r_prv;
      rb    = '0;
      b     = '0;
      for (int j = 0; j < ISQ_PER; j++) begin
        if (k * ISQ_PER + j < lav_pkg::ISQ_STEPS) begin
          b  = SQW'(1) << (SQW - 2 - 2 * (k * ISQ_PER + j));
          rb = {1'b0, r_nxt} + {1'b0, b};
          if ({1'b0, x_nxt} >= rb) begin
            x_nxt = x_nxt - rb[SQW-1:0];
            r_nxt = (r_nxt >> 1) + b;
          end else begin
            r_nxt = r_nxt >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) isv_r[k] <= 1'b0;
      else if (adv) isv_r[k] <= v_prv;
      if (adv) begin
        ism_r[k] <= m_prv;
        isx_r[k] <= x_nxt;
        isr_r[k] <= r_nxt;
      end
    end
  end

  // divide, three lanes
  logic            dv_v_r   [DIV_STG];
  meta_t           dv_m_r   [DIV_STG];
  logic [RTW-1:0]  dv_rt_r  [DIV_STG];
  logic [REMW-1:0] dv_rem_r [DIV_STG][3];
  logic [QW-1:0]   dv_q_r   [DIV_STG][3];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_div
    logic            v_prv;
    meta_t           m_prv;
    logic [RTW-1:0]  rt_prv;
    logic [REMW-1:0] rem_prv [3];
    logic [QW-1:0]   q_prv [3];
    logic [REMW-1:0] rem_nxt [3];
    logic [QW-1:0]   q_nxt [3];

    if (k == 0) begin : g_first
      assign v_prv  = isv_r[ISQ_STG-1];
      assign m_prv  = ism_r[ISQ_STG-1];
      assign rt_prv = isr_r[ISQ_STG-1][RTW-1:0];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_prv[i] = REMW'(ism_r[ISQ_STG-1].nm[i]);
        assign q_prv[i]   = '0;
      end
    end else begin : g_next
      assign v_prv  = dv_v_r[k-1];
      assign m_prv  = dv_m_r[k-1];
      assign rt_prv = dv_rt_r[k-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_prv[i] = dv_rem_r[k-1][i];
        assign q_prv[i]   = dv_q_r[k-1][i];
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = rem_prv[i];
        q_nxt[i]   = q_prv[i];
        for (int j = 0; j < DIV_PER; j++) begin
          if (k * DIV_PER + j < lav_pkg::DIV_STEPS) begin
            if (rem_nxt[i] >= REMW'(rt_prv)) begin
              rem_nxt[i] = (rem_nxt[i] - REMW'(rt_prv)) << 1;
              q_nxt[i]   = {q_nxt[i][QW-2:0], 1'b1};
            end else begin
              rem_nxt[i] = rem_nxt[i] << 1;
              q_nxt[i]   = {q_nxt[i][QW-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k] <= 1'b0;
      else if (adv) dv_v_r[k] <= v_prv;
      if (adv) begin
        dv_m_r[k]  <= m_prv;
        dv_rt_r[k] <= rt_prv;
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k][i] <= rem_nxt[i];
          dv_q_r[k][i]   <= q_nxt[i];
        end
      end
    end
  end

  // sign and zero vector
  logic           o_v_r;
  lav_pkg::unit_t o_vec_r [3];
  lav_pkg::band_t o_band_r;
  lav_pkg::unit_t u_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = $signed({1'b0, dv_q_r[DIV_STG-1][i]});
      if (dv_m_r[DIV_STG-1].zero) u_nxt[i] = '0;
      else if (dv_m_r[DIV_STG-1].neg[i]) u_nxt[i] = -u_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (adv) o_v_r <= dv_v_r[DIV_STG-1];
    if (adv) begin
      o_vec_r  <= u_nxt;
      o_band_r <= dv_m_r[DIV_STG-1].band;
    end
  end

  assign out_vld  = o_v_r;
  assign out_vec  = o_vec_r;
  assign out_band = o_band_r;

endmodule

FILE: hw/rtl/lav_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product: six registered products, then differences.
// ----------------------------------------------------------------------------
module lav_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  lav_pkg::unit_t  in_a [3],
  input  lav_pkg::word_t  in_b [3],
  input  lav_pkg::band_t  in_band,
  output logic            out_vld,
  output lav_pkg::vec_t   out_vec [3],
  output lav_pkg::band_t  out_band
);

  localparam int PRD_W = lav_pkg::UNIT_W + lav_pkg::IN_W;

  logic                    p_v_r;
  logic signed [PRD_W-1:0] p_r [6];
  lav_pkg::band_t          p_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else if (adv) p_v_r <= in_vld;
    if (adv) begin
      p_r[0]   <= $signed(in_a[1]) * $signed(in_b[2]);
      p_r[1]   <= $signed(in_a[2]) * $signed(in_b[1]);
      p_r[2]   <= $signed(in_a[2]) * $signed(in_b[0]);
      p_r[3]   <= $signed(in_a[0]) * $signed(in_b[2]);
      p_r[4]   <= $signed(in_a[0]) * $signed(in_b[1]);
      p_r[5]   <= $signed(in_a[1]) * $signed(in_b[0]);
      p_band_r <= in_band;
    end
  end

  logic           o_v_r;
  lav_pkg::vec_t  o_vec_r [3];
  lav_pkg::band_t o_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (adv) o_v_r <= p_v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        o_vec_r[i] <= lav_pkg::vec_t'(p_r[2*i]) - lav_pkg::vec_t'(p_r[2*i+1]);
      end
      o_band_r <= p_band_r;
    end
  end

  assign out_vld  = o_v_r;
  assign out_vec  = o_vec_r;
  assign out_band = o_band_r;

endmodule

FILE: hw/rtl/lav_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_row
// Translation terms (dot with eye, floor shift, saturate) and the output
// register that sends the three rows of an item one after another.
// ----------------------------------------------------------------------------
module lav_row (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  lav_pkg::unit_t      in_side [3],
  input  lav_pkg::tup_t       in_tup [3],
  input  lav_pkg::unit_t      in_fwd [3],
  input  lav_pkg::word_t      in_eye [3],
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_row_index,
  output lav_pkg::col_t       out_col_x,
  output lav_pkg::col_t       out_col_y,
  output lav_pkg::col_t       out_col_z,
  output lav_pkg::word_t      out_shift_term,
  output logic                out_last_row
);

  localparam int TW    = lav_pkg::TUP_W;
  localparam int CW    = lav_pkg::COL_W;
  localparam int IW    = lav_pkg::IN_W;
  localparam int PRD_W = TW + IW;
  localparam int DOT_W = PRD_W + 2;
  localparam int T_W   = DOT_W + 1;

  function automatic lav_pkg::col_t to_col(input lav_pkg::tup_t v);
    logic signed [TW+CW-1:0] w;
    w = (TW + CW)'(v);
    return w[CW-1:0];
  endfunction

  // products; row 2 uses +fwd, its sign is folded into the term
  logic                    v0_r;
  logic signed [PRD_W-1:0] prd0_r [3][3];
  lav_pkg::col_t           col0_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_vld;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prd0_r[0][i] <= $signed(in_side[i]) * $signed(in_eye[i]);
        prd0_r[1][i] <= $signed(in_tup[i]) * $signed(in_eye[i]);
        prd0_r[2][i] <= $signed(in_fwd[i]) * $signed(in_eye[i]);
        col0_r[0][i] <= to_col(lav_pkg::tup_t'(in_side[i]));
        col0_r[1][i] <= to_col(in_tup[i]);
        col0_r[2][i] <= to_col(-lav_pkg::tup_t'(in_fwd[i]));
      end
    end
  end

  logic                    v1_r;
  logic signed [DOT_W-1:0] dot1_r [3];
  lav_pkg::col_t           col1_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v0_r;
    if (adv) begin
      col1_r <= col0_r;
      for (int k = 0; k < 3; k++) begin
        dot1_r[k] <= DOT_W'(prd0_r[k][0]) + DOT_W'(prd0_r[k][1]) + DOT_W'(prd0_r[k][2]);
      end
    end
  end

  logic                  v2_r;
  lav_pkg::word_t        term2_r [3];
  lav_pkg::col_t         col2_r [3][3];
  logic signed [T_W-1:0] sh_nxt [3];
  lav_pkg::word_t        term_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (k == 2) sh_nxt[k] = T_W'(dot1_r[k]) >>> lav_pkg::FRAC_BITS;
      else sh_nxt[k] = (-T_W'(dot1_r[k])) >>> lav_pkg::FRAC_BITS;
      if (sh_nxt[k][T_W-1:IW-1] == '0 || sh_nxt[k][T_W-1:IW-1] == '1) begin
        term_nxt[k] = sh_nxt[k][IW-1:0];
      end else if (sh_nxt[k][T_W-1]) begin
        term_nxt[k] = {1'b1, {(IW-1){1'b0}}};
      end else begin
        term_nxt[k] = {1'b0, {(IW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      col2_r  <= col1_r;
      term2_r <= term_nxt;
    end
  end

  // output register, one row per handshake
  logic           hv_r;
  logic [1:0]     row_r;
  lav_pkg::col_t  hcol_r [3][3];
  lav_pkg::word_t hterm_r [3];
  logic           take;

  assign take = !hv_r || (out_ready && row_r == lav_pkg::ROW_FWD);
  assign adv  = !v2_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r  <= 1'b0;
      row_r <= lav_pkg::ROW_SIDE;
    end else if (take) begin
      hv_r  <= v2_r;
      row_r <= lav_pkg::ROW_SIDE;
    end else if (out_ready) begin
      row_r <= row_r + 2'd1;
    end
    if (take) begin
      hcol_r  <= col2_r;
      hterm_r <= term2_r;
    end
  end

  always_comb begin
    case (row_r)
      lav_pkg::ROW_UP: begin
        out_col_x      = hcol_r[1][0];
        out_col_y      = hcol_r[1][1];
        out_col_z      = hcol_r[1][2];
        out_shift_term = hterm_r[1];
      end
      lav_pkg::ROW_FWD: begin
        out_col_x      = hcol_r[2][0];
        out_col_y      = hcol_r[2][1];
        out_col_z      = hcol_r[2][2];
        out_shift_term = hterm_r[2];
      end
      default: begin
        out_col_x      = hcol_r[0][0];
        out_col_y      = hcol_r[0][1];
        out_col_z      = hcol_r[0][2];
        out_shift_term = hterm_r[0];
      end
    endcase
  end

  assign out_valid     = hv_r;
  assign out_row_index = row_r;
  assign out_last_row  = (row_r == lav_pkg::ROW_FWD);

endmodule

FILE: hw/rtl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point look-at camera: eye, target and up vector in, view matrix out
// as three rows (side, true up, negated forward) with translation terms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: eye, target and up,
//   each component signed Q16.16.
//   Result channel (out_valid/out_ready) gives three items per input item,
//   rows 0, 1, 2 in order; out_last_row marks row 2.
//   Depth: 68 register stages, the output register included; once the first
//   row of an item is on the outputs, the other two follow as they are taken.
//   The output register sends one row per cycle while out_ready is high and
//   so sets the throughput; the pipeline itself takes one item per cycle
//   while it is not stalled.
//   Most of the depth sits in the two normalize units (square root at two
//   bits a stage, divide at three quotient bits a stage).
//   Reset clears all valid bits; no item or row is in flight afterwards.
//   When the receiver stalls, rows stay on the outputs and the whole pipeline
//   freezes as soon as a finished item waits behind them; in_ready drops then.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_upward_x,
  input  logic signed [31:0] in_upward_y,
  input  logic signed [31:0] in_upward_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row_index,
  output logic signed [17:0] out_col_x,
  output logic signed [17:0] out_col_y,
  output logic signed [17:0] out_col_z,
  output logic signed [31:0] out_shift_term,
  output logic               out_last_row
);

  logic           adv;
  lav_pkg::vec_t  fd_vec [3];
  lav_pkg::band_t in_band;

  always_comb begin
    in_band        = '0;
    in_band.eye[0] = in_eye_x;
    in_band.eye[1] = in_eye_y;
    in_band.eye[2] = in_eye_z;
    in_band.upv[0] = in_upward_x;
    in_band.upv[1] = in_upward_y;
    in_band.upv[2] = in_upward_z;
  end

  assign fd_vec[0] = lav_pkg::vec_t'(in_target_x) - lav_pkg::vec_t'(in_eye_x);
  assign fd_vec[1] = lav_pkg::vec_t'(in_target_y) - lav_pkg::vec_t'(in_eye_y);
  assign fd_vec[2] = lav_pkg::vec_t'(in_target_z) - lav_pkg::vec_t'(in_eye_z);

  // forward
  logic           ua_vld;
  lav_pkg::unit_t ua_vec [3];
  lav_pkg::band_t ua_band;

  lav_unit u_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_vec   (fd_vec),
    .in_band  (in_band),
    .out_vld  (ua_vld),
    .out_vec  (ua_vec),
    .out_band (ua_band)
  );

  lav_pkg::band_t c1_in_band;
  lav_pkg::word_t c1_b [3];

  always_comb begin
    c1_in_band = ua_band;
    for (int i = 0; i < 3; i++) begin
      c1_in_band.fwd[i] = ua_vec[i];
      c1_b[i]           = $signed(ua_band.upv[i]);
    end
  end

  logic           c1_vld;
  lav_pkg::vec_t  c1_vec [3];
  lav_pkg::band_t c1_band;

  lav_cross u_cross_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (ua_vld),
    .in_a     (ua_vec),
    .in_b     (c1_b),
    .in_band  (c1_in_band),
    .out_vld  (c1_vld),
    .out_vec  (c1_vec),
    .out_band (c1_band)
  );

  // side
  logic           ub_vld;
  lav_pkg::unit_t ub_vec [3];
  lav_pkg::band_t ub_band;

  lav_unit u_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (c1_vld),
    .in_vec   (c1_vec),
    .in_band  (c1_band),
    .out_vld  (ub_vld),
    .out_vec  (ub_vec),
    .out_band (ub_band)
  );

  lav_pkg::band_t c2_in_band;
  lav_pkg::word_t c2_b [3];

  always_comb begin
    c2_in_band = ub_band;
    for (int i = 0; i < 3; i++) begin
      c2_in_band.side[i] = ub_vec[i];
      c2_b[i]            = lav_pkg::word_t'($signed(ub_band.fwd[i]));
    end
  end

  logic           c2_vld;
  lav_pkg::vec_t  c2_vec [3];
  lav_pkg::band_t c2_band;

  lav_cross u_cross_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (ub_vld),
    .in_a     (ub_vec),
    .in_b     (c2_b),
    .in_band  (c2_in_band),
    .out_vld  (c2_vld),
    .out_vec  (c2_vec),
    .out_band (c2_band)
  );

  lav_pkg::tup_t  tup [3];
  lav_pkg::unit_t r_side [3];
  lav_pkg::unit_t r_fwd [3];
  lav_pkg::word_t r_eye [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tup[i]    = lav_pkg::tup_t'(c2_vec[i] >>> lav_pkg::FRAC_BITS);
      r_side[i] = $signed(c2_band.side[i]);
      r_fwd[i]  = $signed(c2_band.fwd[i]);
      r_eye[i]  = $signed(c2_band.eye[i]);
    end
  end

  lav_row u_row (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (c2_vld),
    .in_side        (r_side),
    .in_tup         (tup),
    .in_fwd         (r_fwd),
    .in_eye         (r_eye),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_index  (out_row_index),
    .out_col_x      (out_col_x),
    .out_col_y      (out_col_y),
    .out_col_z      (out_col_z),
    .out_shift_term (out_shift_term),
    .out_last_row   (out_last_row)
  );

  assign in_ready = adv;

`ifndef SYNTH
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == lav_pkg::ROW_FWD)))
    else $error("last_row flag does not match row index");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row
    |=> out_valid && out_row_index == $past(out_row_index) + 2'd1)
    else $error("row sequence broken within an item");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !(out_ready && out_last_row))
    else $error("input stalled without a waiting row");
`endif

endmodule

FILE: bench/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_tb
// Self-checking bench for the look-at view matrix: a queue-fed driver and a
// row monitor, checked against an in-bench fixed-point model under phases of
// random idling, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module look_at_view_matrix_tb;

  typedef struct {
    logic signed [31:0] v[9];
  } cam_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [17:0] cx, cy, cz;
    logic signed [31:0] shift;
    logic               last;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_f[9] = '{default: '0};
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_row_index;
  logic signed [17:0] out_col_x, out_col_y, out_col_z;
  logic signed [31:0] out_shift_term;
  logic out_last_row;

  cam_t cam_queue[$];
  row_t rows_due[$];
  int errors = 0;
  int send_idle = 0;
  int send_idle_pct = 0;
  int recv_stall = 0;
  int hold_off = 0;
  bit pause_send = 1'b0;
  longint cycles = 0;

  always #4 clk = ~clk;

  look_at_view_matrix u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_eye_x(in_f[0]), .in_eye_y(in_f[1]), .in_eye_z(in_f[2]),
    .in_target_x(in_f[3]), .in_target_y(in_f[4]), .in_target_z(in_f[5]),
    .in_upward_x(in_f[6]), .in_upward_y(in_f[7]), .in_upward_z(in_f[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_index(out_row_index), .out_col_x(out_col_x), .out_col_y(out_col_y),
    .out_col_z(out_col_z), .out_shift_term(out_shift_term),
    .out_last_row(out_last_row)
  );

  function automatic longint floor_frac(longint x);
    return x >>> lav_pkg::FRAC_BITS;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic to_unit(inout longint v[3]);
    longint unsigned mag[3], top, sum, r;
    bit neg[3];
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) return;
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    r = root64(sum);
    if (r == 0) return;
    for (int i = 0; i < 3; i++) begin
      longint u;
      u = longint'((mag[i] << lav_pkg::FRAC_BITS) / r);
      v[i] = neg[i] ? -u : u;
    end
  endtask

  function automatic void cross_vec(input longint a[3], input longint b[3],
                                    output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  task automatic predict_rows(input cam_t c);
    longint eye[3], fwd[3], upv[3], side[3], raw[3], m[3][3];
    longint dot, t;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      eye[i] = c.v[i];
      fwd[i] = longint'(c.v[3+i]) - eye[i];
      upv[i] = c.v[6+i];
    end
    to_unit(fwd);
    cross_vec(fwd, upv, side);
    to_unit(side);
    cross_vec(side, fwd, raw);
    for (int i = 0; i < 3; i++) begin
      m[0][i] = side[i];
      m[1][i] = floor_frac(raw[i]);
      m[2][i] = -fwd[i];
    end
    for (int k = 0; k < 3; k++) begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot += m[k][i] * eye[i];
      t = floor_frac(-dot);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      r.row = (k == 0) ? lav_pkg::ROW_SIDE : (k == 1) ? lav_pkg::ROW_UP : lav_pkg::ROW_FWD;
      r.cx = m[k][0][17:0];
      r.cy = m[k][1][17:0];
      r.cz = m[k][2][17:0];
      r.shift = t[31:0];
      r.last = (k == 2);
      rows_due.push_back(r);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task automatic add_cam(input logic signed [31:0] e[3], input logic signed [31:0] tg[3],
                         input logic signed [31:0] u[3]);
    cam_t c;
    for (int i = 0; i < 3; i++) begin
      c.v[i] = e[i];
      c.v[3+i] = tg[i];
      c.v[6+i] = u[i];
    end
    cam_queue.push_back(c);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      3: return $signed($urandom_range(0, 512)) - 256;
      default: return $signed($urandom_range(0, 2000 << 16)) - (1000 << 16);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    cam_t seen;
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      seen.v = in_f;
      predict_rows(seen);
    end
    if (in_valid && !in_ready) begin
    end else if (!pause_send && cam_queue.size() > 0 && send_idle == 0) begin
      cam_t c;
      c = cam_queue.pop_front();
      in_valid <= 1'b1;
      for (int i = 0; i < 9; i++) in_f[i] <= c.v[i];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        report("unexpected row", out_row_index, -1);
      end else begin
        row_t w;
        w = rows_due.pop_front();
        if (out_row_index !== w.row) report("row_index", out_row_index, w.row);
        if (out_col_x !== w.cx) report("col_x", out_col_x, w.cx);
        if (out_col_y !== w.cy) report("col_y", out_col_y, w.cy);
        if (out_col_z !== w.cz) report("col_z", out_col_z, w.cz);
        if (out_shift_term !== w.shift) report("shift_term", out_shift_term, w.shift);
        if (out_last_row !== w.last) report("last_row", out_last_row, w.last);
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // receiver
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    send_idle <= ($urandom_range(0, 99) < send_idle_pct) ? 1 : 0;
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] e[3], tg[3], u[3];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: standard camera, zero forward, parallel/zero up, extremes
    add_cam('{0, 0, 5 << 16}, '{0, 0, 0}, '{0, 1 << 16, 0});
    add_cam('{1 << 16, 2 << 16, 3 << 16}, '{1 << 16, 2 << 16, 3 << 16}, '{0, 1 << 16, 0});
    add_cam('{0, 0, 0}, '{0, 4 << 16, 0}, '{0, 1 << 16, 0});
    add_cam('{3, 3, 3}, '{9, 9, 9}, '{0, 0, 0});
    add_cam('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000},
            '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    add_cam('{32'sh80000000, 32'sh80000000, 32'sh80000000},
            '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000});
    add_cam('{32'sh80000000, 0, 32'sh7fffffff}, '{0, 1, 0}, '{1, 0, 0});
    add_cam('{-1, -1, -1}, '{1, 0, -1}, '{32'sh7fffffff, 0, 0});
    add_cam('{1 << 16, 0, 0}, '{1 << 16, 0, 1}, '{0, 0, 32'sh80000000});
    add_cam('{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555},
            '{32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa},
            '{32'sh55555555, 32'shaaaaaaaa, 32'sh55555555});
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 1 || ph == 4) ? 83 : (ph == 3) ? 15 : 0;
      recv_stall    = (ph == 2 || ph == 4) ? 83 : (ph == 3) ? 15 : 0;
      if (ph == 0) hold_off = 400;
      for (int n = 0; n < 86; n++) begin
        for (int i = 0; i < 3; i++) begin
          e[i] = rand_word();
          tg[i] = rand_word();
          u[i] = rand_word();
        end
        add_cam(e, tg, u);
      end
      while (cam_queue.size() > 0 || in_valid) @(posedge clk);
      if (ph == 2) begin
        pause_send = 1'b1;
        while (rows_due.size() > 0) @(posedge clk);
        pause_send = 1'b0;
      end
    end
    recv_stall = 0;
    while (rows_due.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
